### rtl/dsst_pkg.sv
// Package with the shared types and constants of the disk seek service timer.
package dsst_pkg;

	localparam int unsigned CYL_W    = 24;
	localparam int unsigned SECT_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ID_W     = 16;
	localparam int unsigned STRIPE_W = 32;
	localparam int unsigned COEF_W   = 24;
	localparam int unsigned REM_W    = 24;
	localparam int unsigned ROOT_W   = 20;
	localparam int unsigned ACC_W    = 57;
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;

	localparam logic [CYL_W-1:0]  CYL_MAX  = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// Register index codes, taken from paddr[4:2].
	localparam logic [2:0] REG_SPT  = 3'd0;
	localparam logic [2:0] REG_TPC  = 3'd1;
	localparam logic [2:0] REG_COFA = 3'd2;
	localparam logic [2:0] REG_COFB = 3'd3;
	localparam logic [2:0] REG_MINS = 3'd4;
	localparam logic [2:0] REG_HREV = 3'd5;

	// Iteration counts of the shared compare-subtract unit.
	localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd32;
	localparam logic [CNT_W-1:0] SECT_STEPS = 6'd8;
	localparam logic [CNT_W-1:0] ROOT_STEPS = 6'd20;

	typedef struct packed {
		logic [15:0]       spt;
		logic [7:0]        tpc;
		logic [COEF_W-1:0] coef_a;
		logic [COEF_W-1:0] coef_b;
		logic [COEF_W-1:0] min_seek;
		logic [COEF_W-1:0] half_rev;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVC,
		ST_DIVS,
		ST_DIST,
		ST_SQRT,
		ST_MULA,
		ST_MULB,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic req_ready;
		logic fin_ok;
		logic sqrt_mode;
	} ctl_t;

endpackage

### rtl/dsst_ifs.sv
// Valid/ready channel interfaces for requests and replies of the seek timer.
interface dsst_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_stripe;
	logic [31:0] now_time;
	logic [15:0] source_id;

	modport source(output valid, start_stripe, now_time, source_id, input ready);
	modport sink(input valid, start_stripe, now_time, source_id, output ready);
endinterface

interface dsst_rsp_if;
	logic        valid;
	logic        ready;
	logic [23:0] start_cylinder;
	logic [15:0] start_sector;
	logic [31:0] finish_time;
	logic [15:0] dest_id;
	logic        param_error;

	modport source(output valid, start_cylinder, start_sector, finish_time, dest_id,
		param_error, input ready);
	modport sink(input valid, start_cylinder, start_sector, finish_time, dest_id,
		param_error, output ready);
endinterface

### rtl/dsst_apb_regs.sv
// APB configuration register file of the seek timer.
module dsst_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsst_pkg::ADDR_W-1:0]  paddr,
	input  logic [dsst_pkg::DATA_W-1:0]  pwdata,
	output logic [dsst_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output dsst_pkg::cfg_t               cfg
);

	dsst_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spt      <= 16'd88;
			cfg_q.tpc      <= 8'd20;
			cfg_q.coef_a   <= 24'd17341;
			cfg_q.coef_b   <= 24'd281;
			cfg_q.min_seek <= 24'd131072;
			cfg_q.half_rev <= 24'd363725;
		end else if (wr_en) begin
			unique case (idx)
				dsst_pkg::REG_SPT:  cfg_q.spt      <= pwdata[15:0];
				dsst_pkg::REG_TPC:  cfg_q.tpc      <= pwdata[7:0];
				dsst_pkg::REG_COFA: cfg_q.coef_a   <= pwdata[23:0];
				dsst_pkg::REG_COFB: cfg_q.coef_b   <= pwdata[23:0];
				dsst_pkg::REG_MINS: cfg_q.min_seek <= pwdata[23:0];
				dsst_pkg::REG_HREV: cfg_q.half_rev <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			dsst_pkg::REG_SPT:  prdata = {16'd0, cfg_q.spt};
			dsst_pkg::REG_TPC:  prdata = {24'd0, cfg_q.tpc};
			dsst_pkg::REG_COFA: prdata = {8'd0, cfg_q.coef_a};
			dsst_pkg::REG_COFB: prdata = {8'd0, cfg_q.coef_b};
			dsst_pkg::REG_MINS: prdata = {8'd0, cfg_q.min_seek};
			dsst_pkg::REG_HREV: prdata = {8'd0, cfg_q.half_rev};
			default:            prdata = '0;
		endcase
	end

endmodule

### rtl/dsst_cmp_sub.sv
// Shared compare-and-subtract step used for division and square root digits.
module dsst_cmp_sub (
	input  logic [dsst_pkg::REM_W:0]   num,
	input  logic [dsst_pkg::REM_W:0]   trial,
	output logic                       ge,
	output logic [dsst_pkg::REM_W-1:0] rem_next
);

	logic [dsst_pkg::REM_W:0] diff;

	assign diff     = num - trial;
	assign ge       = (num >= trial);
	// Either kept result fits in REM_W bits.
	assign rem_next = ge ? diff[dsst_pkg::REM_W-1:0] : num[dsst_pkg::REM_W-1:0];

endmodule

### rtl/disk_seek_service_timer_core.sv
// Top level of the disk seek service timer: sequencer, datapath and state.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  req     | in  | valid/ready        | start_stripe, now_time, source_id
//  rsp     | out | valid/ready        | start_cylinder, start_sector, finish_time,
//          |     |                    | dest_id, param_error
//  apb     | in  | psel/penable/pready| paddr, pwdata, prdata (six registers)
//
// An item goes from acceptance to its registered reply through 32 quotient steps
// for the cylinder, 8 for the sector and 20 square root steps, all on the one
// shared compare-subtract unit, and through the states around them for the seek
// distance, the two products on the shared multiplier and the sum.
// An item that does not move the head skips the root and products.
// Reset clears the head cylinder, the disk time and the sequencer, and loads
// the register defaults. A reply waiting on a stalled output does not block the
// next item; only a finished item that finds the output still full waits.
module disk_seek_service_timer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dsst_pkg::ADDR_W-1:0] paddr,
	input  logic [dsst_pkg::DATA_W-1:0] pwdata,
	output logic [dsst_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	dsst_req_if.sink                    req,
	dsst_rsp_if.source                  rsp
);

	dsst_pkg::cfg_t   cfg;
	dsst_pkg::state_t state_q, state_d;
	dsst_pkg::ctl_t   ctl;

	// Request and working registers.
	logic [dsst_pkg::TIME_W-1:0]   now_q;
	logic [dsst_pkg::ID_W-1:0]     src_q;
	logic [dsst_pkg::CYL_W-1:0]    divisor_q;
	logic [39:0]                   dvd_q;
	logic [dsst_pkg::REM_W-1:0]    rem_q;
	logic [31:0]                   quo_q;
	logic [dsst_pkg::CNT_W-1:0]    cnt_q;
	logic [dsst_pkg::CYL_W-1:0]    cyl_q;
	logic [dsst_pkg::SECT_W-1:0]   sector_q;
	logic [dsst_pkg::CYL_W-1:0]    dm1_q;
	logic                          perr_q;
	logic [47:0]                   prod_q;
	logic [dsst_pkg::ACC_W-1:0]    acc_q;

	// Architectural state.
	logic [dsst_pkg::CYL_W-1:0]    head_q;
	logic [dsst_pkg::TIME_W-1:0]   time_q;

	// Output register.
	logic                          out_valid_q;
	logic [dsst_pkg::CYL_W-1:0]    out_cyl_q;
	logic [dsst_pkg::SECT_W-1:0]   out_sect_q;
	logic [dsst_pkg::TIME_W-1:0]   out_time_q;
	logic [dsst_pkg::ID_W-1:0]     out_id_q;
	logic                          out_perr_q;

	dsst_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Cylinder divisor: sectors per track times tracks per cylinder.
	logic [dsst_pkg::CYL_W-1:0] divisor_d;
	assign divisor_d = {8'd0, cfg.spt} * {16'd0, cfg.tpc};

	logic last_step;
	assign last_step = (cnt_q == 6'd1);

	// Shared compare-subtract unit. Division brings in one dividend bit a step,
	// the root two radicand bits against the trial value 4*root+1.
	logic [dsst_pkg::REM_W:0]   su_num, su_trial;
	logic                       su_ge;
	logic [dsst_pkg::REM_W-1:0] su_rem;

	always_comb begin
		if (ctl.sqrt_mode) begin
			su_num   = {rem_q[22:0], dvd_q[39:38]};
			su_trial = {3'd0, quo_q[dsst_pkg::ROOT_W-1:0], 2'b01};
		end else begin
			su_num   = {rem_q, dvd_q[39]};
			su_trial = (state_q == dsst_pkg::ST_DIVC) ? {1'b0, divisor_q}
				: {9'd0, cfg.spt};
		end
	end

	dsst_cmp_sub u_step (
		.num      (su_num),
		.trial    (su_trial),
		.ge       (su_ge),
		.rem_next (su_rem)
	);

	logic [31:0] quo_next;
	assign quo_next = {quo_q[30:0], su_ge};

	// Seek distance and coefficient check.
	logic [dsst_pkg::CYL_W-1:0] dist_d, dm1_d;
	logic                       coef_ok, dist_nz, seek_ok;

	assign dist_d  = (cyl_q >= head_q) ? (cyl_q - head_q) : (head_q - cyl_q);
	assign dm1_d   = dist_d - 24'd1;
	assign dist_nz = (dist_d != '0);
	assign coef_ok = !cfg.coef_a[23] && (cfg.coef_a != '0)
		&& !cfg.coef_b[23] && (cfg.coef_b != '0);
	assign seek_ok = dist_nz && coef_ok;

	// Shared multiplier; both coefficients are positive when it is used.
	logic [dsst_pkg::COEF_W-1:0] mul_a, mul_b;
	logic [47:0]                 mul_p;

	always_comb begin
		if (state_q == dsst_pkg::ST_MULA) begin
			mul_a = cfg.coef_a;
			mul_b = {4'd0, quo_q[dsst_pkg::ROOT_W-1:0]};
		end else begin
			mul_a = cfg.coef_b;
			mul_b = dm1_q;
		end
	end

	assign mul_p = {24'd0, mul_a} * {24'd0, mul_b};

	// Finish time: disk time raised to now, plus the whole milliseconds of the sum.
	logic [dsst_pkg::TIME_W-1:0] base_time;
	logic [33:0]                 fin_sum;
	logic [dsst_pkg::TIME_W-1:0] fin_time;

	assign base_time = (time_q < now_q) ? now_q : time_q;
	assign fin_sum   = {2'b00, base_time} + {1'b0, acc_q[dsst_pkg::ACC_W-1:24]};
	assign fin_time  = (fin_sum[33:32] != 2'b00) ? dsst_pkg::TIME_MAX : fin_sum[31:0];

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsst_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (divisor_d != '0)
						state_d = dsst_pkg::ST_DIVC;
					else if (cfg.spt != '0)
						state_d = dsst_pkg::ST_DIVS;
					else
						state_d = dsst_pkg::ST_DIST;
				end
			end
			dsst_pkg::ST_DIVC: if (last_step) state_d = dsst_pkg::ST_DIVS;
			dsst_pkg::ST_DIVS: if (last_step) state_d = dsst_pkg::ST_DIST;
			dsst_pkg::ST_DIST: state_d = seek_ok ? dsst_pkg::ST_SQRT : dsst_pkg::ST_FIN;
			dsst_pkg::ST_SQRT: if (last_step) state_d = dsst_pkg::ST_MULA;
			dsst_pkg::ST_MULA: state_d = dsst_pkg::ST_MULB;
			dsst_pkg::ST_MULB: state_d = dsst_pkg::ST_ACC;
			dsst_pkg::ST_ACC:  state_d = dsst_pkg::ST_FIN;
			dsst_pkg::ST_FIN:  if (ctl.fin_ok) state_d = dsst_pkg::ST_IDLE;
			default:           state_d = dsst_pkg::ST_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		ctl.req_ready = (state_q == dsst_pkg::ST_IDLE);
		ctl.fin_ok    = (state_q == dsst_pkg::ST_FIN) && (!out_valid_q || rsp.ready);
		ctl.sqrt_mode = (state_q == dsst_pkg::ST_SQRT);
	end

	assign req.ready = ctl.req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dsst_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Head cylinder, disk time and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.fin_ok) begin
				head_q      <= cyl_q;
				time_q      <= fin_time;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			dsst_pkg::ST_IDLE: begin
				if (req.valid) begin
					now_q     <= req.now_time;
					src_q     <= req.source_id;
					divisor_q <= divisor_d;
					dvd_q     <= {req.start_stripe, 8'd0};
					rem_q     <= '0;
					quo_q     <= '0;
					cnt_q     <= dsst_pkg::DIV_STEPS;
					// With a zero divisor the cylinder is pinned at the top and,
					// with no sectors per track, the sector is the low stripe bits.
					cyl_q     <= dsst_pkg::CYL_MAX;
					sector_q  <= req.start_stripe[15:0];
				end
			end
			dsst_pkg::ST_DIVC: begin
				quo_q <= quo_next;
				cnt_q <= cnt_q - 6'd1;
				if (last_step) begin
					cyl_q <= (quo_next[31:24] != '0) ? dsst_pkg::CYL_MAX : quo_next[23:0];
					// The sector is the cylinder remainder taken modulo sectors per
					// track; its quotient is below tracks per cylinder, so eight
					// steps on the low byte finish it.
					rem_q <= {8'd0, su_rem[23:8]};
					dvd_q <= {su_rem[7:0], 32'd0};
					cnt_q <= dsst_pkg::SECT_STEPS;
				end else begin
					rem_q <= su_rem;
					dvd_q <= {dvd_q[38:0], 1'b0};
				end
			end
			dsst_pkg::ST_DIVS: begin
				rem_q <= su_rem;
				dvd_q <= {dvd_q[38:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (last_step)
					sector_q <= su_rem[15:0];
			end
			dsst_pkg::ST_DIST: begin
				dm1_q  <= dm1_d;
				perr_q <= dist_nz && !coef_ok;
				acc_q  <= seek_ok
					? {25'd0, cfg.half_rev, 8'd0} + {25'd0, cfg.min_seek, 8'd0}
					: {25'd0, cfg.half_rev, 8'd0};
				rem_q  <= '0;
				quo_q  <= '0;
				dvd_q  <= {dm1_d, 16'd0};
				cnt_q  <= dsst_pkg::ROOT_STEPS;
			end
			dsst_pkg::ST_SQRT: begin
				rem_q <= su_rem;
				quo_q <= quo_next;
				dvd_q <= {dvd_q[37:0], 2'b00};
				cnt_q <= cnt_q - 6'd1;
			end
			dsst_pkg::ST_MULA: prod_q <= mul_p;
			dsst_pkg::ST_MULB: begin
				acc_q  <= acc_q + {9'd0, prod_q};
				prod_q <= mul_p;
			end
			dsst_pkg::ST_ACC: acc_q <= acc_q + {1'b0, prod_q, 8'd0};
			dsst_pkg::ST_FIN: ;
			default: ;
		endcase
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (ctl.fin_ok) begin
			out_cyl_q  <= cyl_q;
			out_sect_q <= sector_q;
			out_time_q <= fin_time;
			out_id_q   <= src_q;
			out_perr_q <= perr_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.start_cylinder = out_cyl_q;
	assign rsp.start_sector   = out_sect_q;
	assign rsp.finish_time    = out_time_q;
	assign rsp.dest_id        = out_id_q;
	assign rsp.param_error    = out_perr_q;

	// The partial root never grows past its width.
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsst_pkg::ST_SQRT) |-> (quo_q[31:dsst_pkg::ROOT_W] == '0))
		else $error("square root register overflowed its width");

	// The cylinder division keeps its partial remainder below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsst_pkg::ST_DIVC) |-> (rem_q < divisor_q))
		else $error("partial remainder not below divisor");

	// A finished item always shows up on the output the cycle after.
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin_ok |=> (rsp.valid && (rsp.finish_time == time_q)))
		else $error("finished item missing from output register");

	// The disk time never runs backwards.
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin_ok |=> (time_q >= $past(time_q)))
		else $error("disk time decreased");

endmodule
